[src/max_pool_2d_forward_macros.svh]
`ifndef MAX_POOL_2D_FORWARD_MACROS_SVH
`define MAX_POOL_2D_FORWARD_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define MP2D_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("max pool check failed");

// next-cycle implication, sampled on clk, off during rst
`define MP2D_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("max pool check failed");

`endif

[src/mp2d_pkg.sv]
`default_nettype none

package mp2d_pkg;

  localparam int MAX_OUT_COLS_DEF = 512;
  localparam int SAMPLE_BITS_DEF  = 16;

  localparam int POOL_W     = 4;
  localparam int DIM_W      = 11;
  localparam int POS_W      = 10;
  localparam int REGION_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT = 2'd2;

  localparam logic [POOL_W-1:0] POOL_RESET = 4'd2;
  localparam logic [POOL_W-1:0] POOL_MAX   = 4'd8;
  localparam logic [DIM_W-1:0]  DIM_RESET  = 11'd28;
  localparam logic [DIM_W-1:0]  DIM_MAX    = 11'd1024;

  // per-sample line buffer request from the position tracker
  typedef struct packed {
    logic update;
    logic first;
    logic emit;
    logic last;
  } req_t;

  function automatic logic [POOL_W-1:0] clamp_pool(input logic [POOL_W-1:0] v);
    if (v == '0) begin
      return POOL_W'(1);
    end else if (v > POOL_MAX) begin
      return POOL_MAX;
    end else begin
      return v;
    end
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (v > DIM_MAX) begin
      return DIM_MAX;
    end else begin
      return v;
    end
  endfunction

endpackage

`default_nettype wire

[src/mp2d_ram.sv]
`default_nettype none

module mp2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[src/mp2d_pos.sv]
`default_nettype none

module mp2d_pos #(
  parameter int MAX_OUT_COLS = mp2d_pkg::MAX_OUT_COLS_DEF,
  localparam int AW  = (MAX_OUT_COLS > 1) ? $clog2(MAX_OUT_COLS) : 1,
  localparam int OCW = $clog2(MAX_OUT_COLS + 1)
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             wr_en,
  input  wire logic [mp2d_pkg::CFG_IDX_W-1:0]   wr_index,
  input  wire logic [mp2d_pkg::CFG_DATA_W-1:0]  wr_data,
  input  wire logic                             step,
  output mp2d_pkg::req_t                        req,
  output logic      [AW-1:0]                    idx
);

  import mp2d_pkg::*;

  localparam int CW = 12;

  logic [POOL_W-1:0]   pool_size;
  logic [DIM_W-1:0]    in_width;
  logic [DIM_W-1:0]    in_height;
  logic [POS_W-1:0]    col_pos;
  logic [POS_W-1:0]    row_pos;
  logic [REGION_W-1:0] col_in_region;
  logic [REGION_W-1:0] row_in_region;
  logic [OCW-1:0]      out_col;

  logic          cfg_hit;
  logic          col_full;
  logic          row_full;
  logic          kept;
  logic          col_last;
  logic          row_last;
  logic          col_wrap;
  logic          row_wrap;
  logic          last_col;
  logic          last_row;
  logic [OCW:0]  out_col_inc;

  always_comb begin
    cfg_hit  = wr_en && (wr_index == REG_POOL_SIZE || wr_index == REG_IN_WIDTH ||
                         wr_index == REG_IN_HEIGHT);
    col_full = (CW'(col_pos) + CW'(pool_size) - CW'(col_in_region) - CW'(1))
               < CW'(in_width);
    row_full = (CW'(row_pos) + CW'(pool_size) - CW'(row_in_region) - CW'(1))
               < CW'(in_height);
    kept     = out_col < OCW'(MAX_OUT_COLS);
    col_last = (CW'(col_in_region) + CW'(1)) >= CW'(pool_size);
    row_last = (CW'(row_in_region) + CW'(1)) >= CW'(pool_size);
    col_wrap = (CW'(col_pos) + CW'(1)) >= CW'(in_width);
    row_wrap = (CW'(row_pos) + CW'(1)) >= CW'(in_height);
    last_col = (out_col == OCW'(MAX_OUT_COLS - 1)) ||
               ((CW'(col_pos) + CW'(1) + CW'(pool_size)) > CW'(in_width));
    last_row = (CW'(row_pos) + CW'(1) + CW'(pool_size)) > CW'(in_height);
    out_col_inc = (OCW + 1)'(out_col) + (OCW + 1)'(1);

    req.update = col_full && row_full && kept;
    req.first  = (col_in_region == '0) && (row_in_region == '0);
    req.emit   = req.update && col_last && row_last;
    req.last   = last_col && last_row;
    idx        = out_col[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size     <= POOL_RESET;
      in_width      <= DIM_RESET;
      in_height     <= DIM_RESET;
      col_pos       <= '0;
      row_pos       <= '0;
      col_in_region <= '0;
      row_in_region <= '0;
      out_col       <= '0;
    end else if (cfg_hit) begin
      unique case (wr_index)
        REG_POOL_SIZE: pool_size <= clamp_pool(wr_data[POOL_W-1:0]);
        REG_IN_WIDTH:  in_width  <= clamp_dim(wr_data[DIM_W-1:0]);
        REG_IN_HEIGHT: in_height <= clamp_dim(wr_data[DIM_W-1:0]);
        default: ;
      endcase
      col_pos       <= '0;
      row_pos       <= '0;
      col_in_region <= '0;
      row_in_region <= '0;
      out_col       <= '0;
    end else if (step) begin
      if (col_wrap) begin
        col_pos       <= '0;
        col_in_region <= '0;
        out_col       <= '0;
        if (row_wrap) begin
          row_pos       <= '0;
          row_in_region <= '0;
        end else begin
          row_pos <= row_pos + POS_W'(1);
          if (row_last) begin
            row_in_region <= '0;
          end else begin
            row_in_region <= row_in_region + REGION_W'(1);
          end
        end
      end else begin
        col_pos <= col_pos + POS_W'(1);
        if (col_last) begin
          col_in_region <= '0;
          if (out_col_inc < (OCW + 1)'(MAX_OUT_COLS)) begin
            out_col <= out_col_inc[OCW-1:0];
          end else begin
            out_col <= OCW'(MAX_OUT_COLS);
          end
        end else begin
          col_in_region <= col_in_region + REGION_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

[src/mp2d_rmw.sv]
`default_nettype none

`include "max_pool_2d_forward_macros.svh"

module mp2d_rmw #(
  parameter int MAX_OUT_COLS = mp2d_pkg::MAX_OUT_COLS_DEF,
  parameter int SAMPLE_BITS  = mp2d_pkg::SAMPLE_BITS_DEF,
  localparam int AW = (MAX_OUT_COLS > 1) ? $clog2(MAX_OUT_COLS) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire mp2d_pkg::req_t                req,
  input  wire logic        [AW-1:0]          idx,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed      [SAMPLE_BITS-1:0] pooled,
  output logic                               map_done
);

  import mp2d_pkg::*;

  logic                          s1_valid;
  req_t                          s1_req;
  logic [AW-1:0]                 s1_idx;
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  logic                          fwd_valid;
  logic signed [SAMPLE_BITS-1:0] fwd_data;

  logic                          accept;
  logic                          stall;
  logic                          retire;
  logic                          ram_we;
  logic [AW-1:0]                 wr_addr;
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic signed [SAMPLE_BITS-1:0] old_max;
  logic signed [SAMPLE_BITS-1:0] merged;

  always_comb begin
    stall    = s1_valid && s1_req.emit && out_valid && !out_ready;
    retire   = s1_valid && !stall;
    in_ready = !stall;
    accept   = in_valid && in_ready;
    ram_we   = retire && s1_req.update;
    wr_addr  = s1_idx;
    old_max  = fwd_valid ? fwd_data : rd_data;
    if (s1_req.first || (s1_sample > old_max)) begin
      merged = s1_sample;
    end else begin
      merged = old_max;
    end
  end

  mp2d_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_OUT_COLS)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_addr),
    .wr_data (merged),
    .rd_en   (accept),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (retire) begin
        s1_valid <= 1'b0;
      end
      if (retire && s1_req.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // stage payload, forwarding path and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req    <= req;
      s1_idx    <= idx;
      s1_sample <= sample;
      fwd_valid <= ram_we && (wr_addr == idx);
      fwd_data  <= merged;
    end
    if (retire && s1_req.emit) begin
      pooled   <= merged;
      map_done <= s1_req.last;
    end
  end

  `MP2D_ASSERT_SAME(a_emit_in_kept_region, s1_valid && s1_req.emit, s1_req.update)
  `MP2D_ASSERT_NEXT(a_emit_reaches_out, retire && s1_req.emit, out_valid)
  `MP2D_ASSERT_NEXT(a_fwd_value, accept && ram_we && wr_addr == idx, fwd_valid && fwd_data == $past(merged))
  `MP2D_ASSERT_NEXT(a_stall_holds_stage, stall, s1_valid && $stable(s1_idx) && $stable(s1_sample))

endmodule

`default_nettype wire

[src/max_pool_2d_forward.sv]
// a region's last sample passes the sample stage and then the result register before its pooled value is on out_valid
// throughput: one sample per cycle while in_ready is high; the line buffer does one read and
//   one write-back per cycle, with same-entry forwarding between back-to-back samples
// out_ready low stalls input only while a new pooled value waits behind the result register
// reset: pool_size 2, in_width 28, in_height 28, stream at the first sample of a map;
//   the line buffer is not cleared, each entry is written by its region's first sample
`default_nettype none

module max_pool_2d_forward #(
  parameter int MAX_OUT_COLS = mp2d_pkg::MAX_OUT_COLS_DEF,
  parameter int SAMPLE_BITS  = mp2d_pkg::SAMPLE_BITS_DEF,
  localparam int AW = (MAX_OUT_COLS > 1) ? $clog2(MAX_OUT_COLS) : 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            wr_en,
  input  wire logic [mp2d_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [mp2d_pkg::CFG_DATA_W-1:0] wr_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]   sample,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [SAMPLE_BITS-1:0]        pooled,
  output logic                                 map_done
);

  import mp2d_pkg::*;

  req_t          req;
  logic [AW-1:0] idx;
  logic          step;

  assign step = in_valid && in_ready;

  mp2d_pos #(
    .MAX_OUT_COLS (MAX_OUT_COLS)
  ) u_pos (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .step     (step),
    .req      (req),
    .idx      (idx)
  );

  mp2d_rmw #(
    .MAX_OUT_COLS (MAX_OUT_COLS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_rmw (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .req       (req),
    .idx       (idx),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pooled    (pooled),
    .map_done  (map_done)
  );

endmodule

`default_nettype wire

[tb/max_pool_2d_forward_checker.sv]
module max_pool_2d_checker (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        wr_en,
  input  logic [mp2d_pkg::CFG_IDX_W-1:0]              wr_index,
  input  logic [mp2d_pkg::CFG_DATA_W-1:0]             wr_data,
  input  logic                                        in_valid,
  input  logic                                        in_ready,
  input  logic signed [mp2d_pkg::SAMPLE_BITS_DEF-1:0] sample,
  input  logic                                        out_valid,
  input  logic                                        out_ready,
  input  logic signed [mp2d_pkg::SAMPLE_BITS_DEF-1:0] pooled,
  input  logic                                        map_done,
  output int                                          fail_count,
  output int                                          pending,
  output int                                          checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import mp2d_pkg::*;

  localparam int BAND_AW = $clog2(MAX_OUT_COLS_DEF);

  typedef struct packed {
    logic signed [SAMPLE_BITS_DEF-1:0] value;
    logic                              last;
  } pool_out_t;

  pool_out_t expected_pools[$];

  logic [POOL_W-1:0] pool_reg;
  logic [DIM_W-1:0]  width_reg;
  logic [DIM_W-1:0]  height_reg;

  logic signed [SAMPLE_BITS_DEF-1:0] band_max [MAX_OUT_COLS_DEF];
  logic [POS_W-1:0]    col_pos;
  logic [POS_W-1:0]    row_pos;
  logic [REGION_W-1:0] col_in_reg;
  logic [REGION_W-1:0] row_in_reg;
  logic [POS_W-1:0]    out_col;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic void restart_map();
    col_pos = '0;
    row_pos = '0;
    col_in_reg = '0;
    row_in_reg = '0;
    out_col = '0;
  endfunction

  function automatic void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_POOL_SIZE: begin
        pool_reg = data[POOL_W-1:0];
        restart_map();
      end
      REG_IN_WIDTH: begin
        width_reg = data[DIM_W-1:0];
        restart_map();
      end
      REG_IN_HEIGHT: begin
        height_reg = data[DIM_W-1:0];
        restart_map();
      end
      default: begin
      end
    endcase
  endfunction

  // one sample in, at most one pooled value queued
  function automatic void predict_pool(input logic signed [SAMPLE_BITS_DEF-1:0] s);
    int p;
    int w;
    int h;
    int out_w;
    int out_h;
    pool_out_t res;
    p = (pool_reg == 0) ? 1 : (pool_reg > POOL_MAX) ? int'(POOL_MAX) : int'(pool_reg);
    w = (width_reg == 0) ? 1 : (width_reg > DIM_MAX) ? int'(DIM_MAX) : int'(width_reg);
    h = (height_reg == 0) ? 1 : (height_reg > DIM_MAX) ? int'(DIM_MAX) : int'(height_reg);
    out_w = w / p;
    out_h = h / p;
    if (out_w > MAX_OUT_COLS_DEF) out_w = MAX_OUT_COLS_DEF;

    if (out_w > 0 && out_h > 0 && col_pos < out_w * p && row_pos < out_h * p &&
        out_col < out_w) begin
      if (col_in_reg == 0 && row_in_reg == 0) begin
        band_max[out_col[BAND_AW-1:0]] = s;
      end else if (s > band_max[out_col[BAND_AW-1:0]]) begin
        band_max[out_col[BAND_AW-1:0]] = s;
      end
      if (col_in_reg + 1 >= p && row_in_reg + 1 >= p) begin
        res.value = band_max[out_col[BAND_AW-1:0]];
        res.last = (out_col + 1 == out_w) && (row_pos + 1 == out_h * p);
        expected_pools.push_back(res);
      end
    end

    if (col_pos + 1 >= w) begin
      col_pos = '0;
      col_in_reg = '0;
      out_col = '0;
      if (row_pos + 1 >= h) begin
        row_pos = '0;
        row_in_reg = '0;
      end else begin
        row_pos = row_pos + 1'b1;
        if (row_in_reg + 1 >= p) row_in_reg = '0;
        else row_in_reg = row_in_reg + 1'b1;
      end
    end else begin
      col_pos = col_pos + 1'b1;
      if (col_in_reg + 1 >= p) begin
        col_in_reg = '0;
        if (out_col + 1 < MAX_OUT_COLS_DEF) out_col = out_col + 1'b1;
        else out_col = POS_W'(MAX_OUT_COLS_DEF);
      end else begin
        col_in_reg = col_in_reg + 1'b1;
      end
    end
  endfunction

  always @(posedge clk) begin
    pool_out_t exp_pool;
    if (rst) begin
      pool_reg = POOL_RESET;
      width_reg = DIM_RESET;
      height_reg = DIM_RESET;
      foreach (band_max[i]) band_max[i] = '0;
      restart_map();
      expected_pools.delete();
    end else begin
      if (out_valid === 1'b1 && out_ready) begin
        if (expected_pools.size() == 0) begin
          report_mismatch($sformatf("pooled value %0d with none expected", pooled));
        end else begin
          exp_pool = expected_pools.pop_front();
          if (pooled !== exp_pool.value)
            report_mismatch($sformatf("pooled %0d, expected %0d", pooled, exp_pool.value));
          if (map_done !== exp_pool.last)
            report_mismatch($sformatf("map_done %b, expected %b", map_done, exp_pool.last));
          checked++;
        end
      end
      if (wr_en) write_reg(wr_index, wr_data);
      if (in_valid && in_ready) predict_pool(sample);
    end
    pending <= expected_pools.size();
  end

endmodule

[tb/tb_max_pool_2d_forward.sv]
module tb_max_pool_2d_forward;
  timeunit 1ns;
  timeprecision 1ps;
  import mp2d_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int RANDOM_SAMPLES = 1850;
  localparam int LONG_STALL = 300;

  localparam logic [15:0] EDGE_SAMPLES [8] = '{
    16'h8000, 16'h8000, 16'h1234, 16'hffff,
    16'h8000, 16'h8000, 16'h7fff, 16'h0000
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] wr_index = '0;
  logic [CFG_DATA_W-1:0] wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SAMPLE_BITS_DEF-1:0] sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_BITS_DEF-1:0] pooled;
  logic map_done;

  int fail_count;
  int pending;
  int checked;
  int send_idle_pct = 37;
  int recv_idle_pct = 78;
  int stall_requests = 0;
  int stall_served = 0;
  int stall_left = 0;
  int samples_sent = 0;
  int settings_used = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  max_pool_2d_forward DUT (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample(sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pooled(pooled),
    .map_done(map_done)
  );

  max_pool_2d_checker u_checker (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample(sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pooled(pooled),
    .map_done(map_done),
    .fail_count(fail_count),
    .pending(pending),
    .checked(checked)
  );

  // receiver side, with long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_served < stall_requests) begin
      out_ready <= 1'b0;
      stall_left <= LONG_STALL;
      stall_served <= stall_served + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic signed [SAMPLE_BITS_DEF-1:0] rand_sample();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return SAMPLE_BITS_DEF'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_BITS_DEF-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    samples_sent++;
  endtask

  // block idle: every pooled value out, then a settling wait for ignored samples
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic configure(input int p, input int w, input int h);
    wait_drained();
    set_reg(REG_POOL_SIZE, {(CFG_DATA_W-POOL_W)'($urandom), POOL_W'(p)});
    set_reg(REG_IN_WIDTH, CFG_DATA_W'(w));
    set_reg(REG_IN_HEIGHT, CFG_DATA_W'(h));
    settings_used++;
  endtask

  initial begin
    int k;
    int p;
    int w;
    int h;
    int n;
    int sel;
    int rand_sent;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // one full map with extreme values
    configure(2, 4, 2);
    foreach (EDGE_SAMPLES[i]) send_sample(EDGE_SAMPLES[i]);
    // zero pool size acts as one
    configure(0, 3, 1);
    send_sample(16'h7fff);
    send_sample(16'h8000);
    send_sample(16'h5555);
    // region larger than the map, zero height
    configure(15, 2, 0);
    send_sample(16'h7fff);
    send_sample(16'haaaa);
    // write to an unused index mid-region keeps the position
    configure(2, 2, 2);
    send_sample(16'h0001);
    send_sample(16'h8000);
    wait_drained();
    set_reg(REG_UNUSED, '1);
    send_sample(16'hfffe);
    send_sample(16'h0100);
    // valid register write mid-map restarts it
    send_sample(16'h7fff);
    send_sample(16'h7fff);
    wait_drained();
    set_reg(REG_IN_HEIGHT, CFG_DATA_W'(2));
    repeat (4) send_sample(rand_sample());

    rand_sent = 0;
    k = 0;
    while (rand_sent < RANDOM_SAMPLES) begin
      if (rand_sent < RANDOM_SAMPLES / 3) begin
        send_idle_pct = 37;
        recv_idle_pct <= 78;
      end else if (rand_sent < 2 * RANDOM_SAMPLES / 3) begin
        send_idle_pct = 78;
        recv_idle_pct <= 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      case (k)
        1: begin
          p = 1; w = 2047; h = 1; n = 530;
        end
        3: begin
          p = 1; w = 1024; h = 2047; n = 40;
        end
        5: begin
          p = 2; w = 5; h = 1024; n = 60;
        end
        7: begin
          p = 8; w = 16; h = 16; n = 256;
        end
        default: begin
          sel = $urandom_range(9);
          if (sel < 6) p = $urandom_range(1, 4);
          else if (sel < 8) p = $urandom_range(5, 8);
          else if (sel == 8) p = 0;
          else p = $urandom_range(9, 15);
          w = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 12);
          h = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 10);
          n = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h) * $urandom_range(1, 3);
          if ($urandom_range(3) == 0) n += $urandom_range(0, 5);
          if (n > 200) n = 200;
        end
      endcase
      configure(p, w, h);
      if (k == 1 || k == 7) stall_requests <= stall_requests + 1;
      repeat (n) begin
        send_sample(rand_sample());
        rand_sent++;
      end
      k++;
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("tb: %0d samples sent under %0d register settings, %0d pooled values checked",
             samples_sent, settings_used, checked);
    $display("tb: pool sizes 0..15, ragged edges, column cap, restarts and long output stalls");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
